// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the region coalescing table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle implication failed");

`endif

// ----- src/rct_pkg.sv -----
// Package with the types and constants of the region coalescing table.
package rct_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam int ADDR_W    = 32;
	localparam int LEN_W     = 33;
	localparam int ACC_W     = 2;
	localparam int SUM_W     = 34;
	localparam int STATUS_W  = 3;
	localparam int INDEX_W   = 6;
	localparam int TOTAL_W   = 7;

	// One past the highest byte address.
	localparam logic [SUM_W-1:0] ADDR_LIMIT = 34'h1_0000_0000;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED = 3'd0,
		ST_MERGED   = 3'd1,
		ST_INVALID  = 3'd2,
		ST_OVERLAP  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] virt;
		logic [ADDR_W-1:0] phys;
		logic [LEN_W-1:0]  length;
		logic [ACC_W-1:0]  user;
		logic [ACC_W-1:0]  system;
	} entry_t;

endpackage

// ----- src/region_coalescing_table.sv -----
// Top level of the region coalescing table: table memory, scan sequencer and result register.

// Region coalescing table. Each word accepted on the region channel is a mapped
// region (virtual base, physical base, length, user and system access). The block
// answers every region with exactly one word on the result channel: appended,
// merged, invalid, overlap or table full, with the slot touched, its virtual base
// and length after the update, and the number of occupied slots. All slots live in
// one synchronous single-port-write memory with a registered read; the
// sequencer reads one slot per cycle in insertion order and stops at the first
// slot that overlaps the region or touches it with equal access levels. A merge is
// written back in the same cycle as the compare, an append in the cycle after the
// scan. The scan length, one slot per memory read, sets how long a region takes,
// and the sequencer returns to idle before it takes the next region.
// The block takes one region at a time: region_stall is low only while the
// sequencer is idle, and a result that is still waiting in the output register
// does not keep the next region from being accepted and scanned. No unwritten
// slot is ever compared, so the memory needs no clearing after reset.
module region_coalescing_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          region_valid,
	output logic                          region_stall,
	input  logic [rct_pkg::ADDR_W-1:0]    virt_base,
	input  logic [rct_pkg::ADDR_W-1:0]    phys_base,
	input  logic [rct_pkg::LEN_W-1:0]     region_length,
	input  logic [rct_pkg::ACC_W-1:0]     user_access,
	input  logic [rct_pkg::ACC_W-1:0]     system_access,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [rct_pkg::STATUS_W-1:0]  status,
	output logic [rct_pkg::INDEX_W-1:0]   entry_index,
	output logic [rct_pkg::ADDR_W-1:0]    entry_virt,
	output logic [rct_pkg::LEN_W-1:0]     entry_length,
	output logic [rct_pkg::TOTAL_W-1:0]   entry_total
);
	import rct_pkg::*;

	`include "assert_macros.svh"

	// The slot memory: one entry per slot, read data registered.
	entry_t            mem [MAX_SLOTS];
	entry_t            rd_data_q;
	logic [SLOT_W-1:0] rd_addr;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_data;

	// Sequencer state and the region under test.
	state_t            state_q, state_d;
	logic [SLOT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0]  count_q, count_d;
	entry_t            region_q;
	logic [SUM_W-1:0]  vend_q;
	logic              invalid_q;

	// Result waiting to move into the output register.
	status_t           res_status_q, res_status_d;
	logic [SLOT_W-1:0] res_index_q, res_index_d;
	logic [ADDR_W-1:0] res_virt_q, res_virt_d;
	logic [LEN_W-1:0]  res_len_q, res_len_d;
	logic [CNT_W-1:0]  res_total_q, res_total_d;

	// Output register.
	logic              out_valid_q;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_index_q;
	logic [ADDR_W-1:0] out_virt_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [CNT_W-1:0]  out_total_q;
	logic              out_load;

	// Input checks and the compare against the slot just read.
	logic              in_accept;
	logic [SUM_W-1:0]  in_vend;
	logic [SUM_W-1:0]  in_pend;
	logic [SUM_W-1:0]  slot_end;
	logic              hit_overlap;
	logic              hit_touch;
	logic              last_slot;

	assign in_accept = region_valid && !region_stall;
	assign region_stall = (state_q != S_IDLE);

	assign in_vend = SUM_W'(virt_base) + SUM_W'(region_length);
	assign in_pend = SUM_W'(phys_base) + SUM_W'(region_length);

	assign slot_end    = SUM_W'(rd_data_q.virt) + SUM_W'(rd_data_q.length);
	assign hit_overlap = (SUM_W'(rd_data_q.virt) < vend_q) &&
		(slot_end > SUM_W'(region_q.virt));
	assign hit_touch   = (rd_data_q.user == region_q.user) &&
		(rd_data_q.system == region_q.system) &&
		((slot_end == SUM_W'(region_q.virt)) || (SUM_W'(rd_data_q.virt) == vend_q));
	assign last_slot   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// The output register is free when empty or when its word leaves this cycle.
	assign out_load = (state_q == S_RESULT) && (!out_valid_q || !result_stall);

	// Memory: a write and a registered read each cycle. A merge writes a slot as
	// the scan leaves it, and the next region's first read comes only after the
	// result and idle states, so the sequencer itself keeps a merge write and the
	// reads of that slot apart.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Next state, memory control and the result of the item.
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		count_d      = count_q;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = idx_q;
		wr_data      = region_q;
		res_status_d = res_status_q;
		res_index_d  = res_index_q;
		res_virt_d   = res_virt_q;
		res_len_d    = res_len_q;
		res_total_d  = res_total_q;

		unique case (state_q)
			S_IDLE: begin
				// Slot 0 is read while idle, so its word is ready for the scan.
				idx_d = '0;
				if (in_accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				rd_addr = idx_q + SLOT_W'(1);
				res_index_d = '0;
				res_virt_d  = '0;
				res_len_d   = '0;
				res_total_d = count_q;
				if (invalid_q) begin
					res_status_d = ST_INVALID;
					state_d = S_RESULT;
				end else if (count_q == '0) begin
					state_d = S_APPEND;
				end else if (hit_overlap) begin
					res_status_d = ST_OVERLAP;
					state_d = S_RESULT;
				end else if (hit_touch) begin
					// Lower base wins, lengths add, physical base stays.
					wr_en = 1'b1;
					wr_data = rd_data_q;
					if (region_q.virt < rd_data_q.virt) begin
						wr_data.virt = region_q.virt;
					end
					wr_data.length = LEN_W'(SUM_W'(rd_data_q.length) +
						SUM_W'(region_q.length));
					res_status_d = ST_MERGED;
					res_index_d  = idx_q;
					res_virt_d   = wr_data.virt;
					res_len_d    = wr_data.length;
					state_d = S_RESULT;
				end else if (last_slot) begin
					state_d = S_APPEND;
				end else begin
					idx_d = idx_q + SLOT_W'(1);
				end
			end
			S_APPEND: begin
				res_total_d = count_q;
				res_index_d = '0;
				res_virt_d  = '0;
				res_len_d   = '0;
				if (count_q == CNT_W'(MAX_SLOTS)) begin
					res_status_d = ST_FULL;
				end else begin
					wr_en = 1'b1;
					wr_addr = count_q[SLOT_W-1:0];
					count_d = count_q + CNT_W'(1);
					res_status_d = ST_APPENDED;
					res_index_d  = count_q[SLOT_W-1:0];
					res_virt_d   = region_q.virt;
					res_len_d    = region_q.length;
					res_total_d  = count_q + CNT_W'(1);
				end
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the region under test, the pending result, the output.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			region_q.virt   <= virt_base;
			region_q.phys   <= phys_base;
			region_q.length <= region_length;
			region_q.user   <= user_access;
			region_q.system <= system_access;
			vend_q          <= in_vend;
			invalid_q       <= (region_length == '0) || (in_vend > ADDR_LIMIT) ||
				(in_pend > ADDR_LIMIT);
		end
		res_status_q <= res_status_d;
		res_index_q  <= res_index_d;
		res_virt_q   <= res_virt_d;
		res_len_q    <= res_len_d;
		res_total_q  <= res_total_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_virt_q   <= res_virt_q;
			out_len_q    <= res_len_q;
			out_total_q  <= res_total_q;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign entry_index  = INDEX_W'(out_index_q);
	assign entry_virt   = out_virt_q;
	assign entry_length = out_len_q;
	assign entry_total  = TOTAL_W'(out_total_q);

	// The occupancy never passes the table size.
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_SLOTS))
	// Only the append step changes the occupancy.
	`ASSERT_NEXT(a_count_append_only, clk, arst_n, state_q != S_APPEND, $stable(count_q))
	// An appended word always reports a nonempty table.
	`ASSERT_IMPLIES(a_append_total, clk, arst_n,
		out_valid_q && (out_status_q == ST_APPENDED), out_total_q != '0)
	// The memory is written only while the scan or the append step runs.
	`ASSERT_IMPLIES(a_write_window, clk, arst_n, wr_en,
		(state_q == S_SCAN) || (state_q == S_APPEND))

endmodule

// ----- bench/region_table_checker.sv -----
`timescale 1ns / 100ps
// Checker for the region coalescing table: predicts every result word and compares it.
module region_table_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         region_valid,
	input  logic                         region_stall,
	input  logic [rct_pkg::ADDR_W-1:0]   virt_base,
	input  logic [rct_pkg::ADDR_W-1:0]   phys_base,
	input  logic [rct_pkg::LEN_W-1:0]    region_length,
	input  logic [rct_pkg::ACC_W-1:0]    user_access,
	input  logic [rct_pkg::ACC_W-1:0]    system_access,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  logic [rct_pkg::STATUS_W-1:0] status,
	input  logic [rct_pkg::INDEX_W-1:0]  entry_index,
	input  logic [rct_pkg::ADDR_W-1:0]   entry_virt,
	input  logic [rct_pkg::LEN_W-1:0]    entry_length,
	input  logic [rct_pkg::TOTAL_W-1:0]  entry_total,
	output int                           mismatches,
	output int                           pending
);
	import rct_pkg::*;

	typedef struct {
		status_t             st;
		logic [INDEX_W-1:0]  slot;
		logic [ADDR_W-1:0]   virt;
		logic [LEN_W-1:0]    length;
		logic [TOTAL_W-1:0]  total;
	} result_word_t;

	// Shadow copy of the table. The physical base is never visible on the result
	// channel, so it is not kept.
	logic [ADDR_W-1:0] tbl_virt   [MAX_SLOTS];
	logic [LEN_W-1:0]  tbl_len    [MAX_SLOTS];
	logic [ACC_W-1:0]  tbl_user   [MAX_SLOTS];
	logic [ACC_W-1:0]  tbl_system [MAX_SLOTS];
	int unsigned       tbl_count;

	result_word_t expected_words[$];
	int           miss_count;

	function automatic result_word_t coalesce_region(input logic [ADDR_W-1:0] v,
			input logic [ADDR_W-1:0] p, input logic [LEN_W-1:0] len,
			input logic [ACC_W-1:0] u, input logic [ACC_W-1:0] s);
		result_word_t r;
		logic [SUM_W-1:0] v_end;
		logic [SUM_W-1:0] p_end;
		logic [SUM_W-1:0] s_end;
		r.st = ST_INVALID;
		r.slot = '0;
		r.virt = '0;
		r.length = '0;
		r.total = TOTAL_W'(tbl_count);
		v_end = SUM_W'(v) + SUM_W'(len);
		p_end = SUM_W'(p) + SUM_W'(len);
		if (len == '0 || v_end > ADDR_LIMIT || p_end > ADDR_LIMIT)
			return r;
		for (int i = 0; i < tbl_count; i++) begin
			s_end = SUM_W'(tbl_virt[i]) + SUM_W'(tbl_len[i]);
			if (SUM_W'(tbl_virt[i]) < v_end && s_end > SUM_W'(v)) begin
				r.st = ST_OVERLAP;
				return r;
			end
			if (tbl_user[i] == u && tbl_system[i] == s &&
					(s_end == SUM_W'(v) || SUM_W'(tbl_virt[i]) == v_end)) begin
				if (v < tbl_virt[i])
					tbl_virt[i] = v;
				tbl_len[i] = tbl_len[i] + len;
				r.st = ST_MERGED;
				r.slot = INDEX_W'(i);
				r.virt = tbl_virt[i];
				r.length = tbl_len[i];
				return r;
			end
		end
		if (tbl_count >= MAX_SLOTS) begin
			r.st = ST_FULL;
			return r;
		end
		tbl_virt[tbl_count] = v;
		tbl_len[tbl_count] = len;
		tbl_user[tbl_count] = u;
		tbl_system[tbl_count] = s;
		r.st = ST_APPENDED;
		r.slot = INDEX_W'(tbl_count);
		r.virt = v;
		r.length = len;
		tbl_count++;
		r.total = TOTAL_W'(tbl_count);
		return r;
	endfunction

	task automatic note_miss(input string what, input logic [63:0] want, input logic [63:0] got);
		miss_count++;
		if (miss_count <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		result_word_t fresh;
		if (!arst_n) begin
			tbl_count = 0;
			miss_count = 0;
			expected_words.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			// A result word taken at this edge belongs to an older region than one
			// taken on the region channel at the same edge, so it is checked first.
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					note_miss("unrequested result word, status", '0, status);
				end else begin
					want = expected_words.pop_front();
					if (status !== want.st)
						note_miss("status", want.st, status);
					if (entry_index !== want.slot)
						note_miss("entry_index", want.slot, entry_index);
					if (entry_virt !== want.virt)
						note_miss("entry_virt", want.virt, entry_virt);
					if (entry_length !== want.length)
						note_miss("entry_length", want.length, entry_length);
					if (entry_total !== want.total)
						note_miss("entry_total", want.total, entry_total);
				end
			end
			if (region_valid && !region_stall) begin
				fresh = coalesce_region(virt_base, phys_base, region_length,
					user_access, system_access);
				expected_words = {expected_words, fresh};
			end
			mismatches <= miss_count;
			pending <= expected_words.size();
		end
	end

endmodule

// ----- bench/tb_region_coalescing_table.sv -----
`timescale 1ns / 100ps
// Testbench top of the region coalescing table: clock, reset, stimulus, stalls and verdict.
module tb_region_coalescing_table;
	import rct_pkg::*;

	// The random regions mostly grow a set of lanes, one per 64 MB window in the
	// lower part of the address space, so that merges keep happening in both
	// directions; the directed words that stay in the table live above the lanes.
	localparam int          NUM_LANES    = 40;
	localparam logic [31:0] LANE_SPAN    = 32'h0400_0000;
	localparam int          RANDOM_WORDS = 1600;
	// The limit on quiet cycles lies well above a full scan, the longest receiver
	// stall run and the longest sender gap, so a quiet stretch that reaches it
	// means a hang.
	localparam int          IDLE_LIMIT   = 4000;
	localparam int          DRAIN_CYCLES = 100;

	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS, STALL_HEAVY} stall_mode_t;
	typedef enum int {BAD_ZERO, BAD_VIRT_END, BAD_PHYS_END, BAD_HUGE} bad_kind_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                region_valid   = 1'b0;
	logic                region_stall;
	logic [ADDR_W-1:0]   virt_base      = '0;
	logic [ADDR_W-1:0]   phys_base      = '0;
	logic [LEN_W-1:0]    region_length  = '0;
	logic [ACC_W-1:0]    user_access    = '0;
	logic [ACC_W-1:0]    system_access  = '0;
	logic                result_valid;
	logic                result_stall   = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  entry_index;
	logic [ADDR_W-1:0]   entry_virt;
	logic [LEN_W-1:0]    entry_length;
	logic [TOTAL_W-1:0]  entry_total;
	int                  mismatches;
	int                  pending;

	// Lane bookkeeping: the span that has been offered so far and the access pair
	// that the lane merges with.
	logic [ADDR_W-1:0] lane_lo     [NUM_LANES];
	logic [ADDR_W-1:0] lane_hi     [NUM_LANES];
	logic [ACC_W-1:0]  lane_user   [NUM_LANES];
	logic [ACC_W-1:0]  lane_system [NUM_LANES];

	int burst_left  = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	region_coalescing_table uut (.*);

	region_table_checker u_checker (.*);

	// Receiver stalls: the mode is redrawn at random among no stalls at all, sparse
	// single stalls, long on and off runs, and mostly stalled.
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          run_left   = 0;
	logic        run_on     = 1'b0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(50, 400);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE: begin
				result_stall <= 1'b0;
			end
			STALL_SPARSE: begin
				result_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_RUNS: begin
				if (run_left == 0) begin
					run_on = !run_on;
					run_left = $urandom_range(1, 20);
				end
				run_left--;
				result_stall <= run_on;
			end
			default: begin
				result_stall <= ($urandom_range(0, 3) != 0);
			end
		endcase
	end

	// Watchdog: any cycle without a word moving on either channel counts toward
	// the limit; a single accepted word clears it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((region_valid && !region_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offers one region word and returns at the edge where it is taken. The sender
	// works in bursts; between bursts valid drops for a random gap, and about a
	// quarter of the bursts start with no gap at all, which gives long unbroken
	// stretches. Valid stays high from one word to the next inside a burst.
	task automatic send_region(input logic [ADDR_W-1:0] v, input logic [ADDR_W-1:0] p,
			input logic [LEN_W-1:0] len, input logic [ACC_W-1:0] u,
			input logic [ACC_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				region_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		region_valid <= 1'b1;
		virt_base <= v;
		phys_base <= p;
		region_length <= len;
		user_access <= u;
		system_access <= s;
		@(posedge clk);
		while (region_stall)
			@(posedge clk);
	endtask

	// A physical base that keeps the physical end within the address space when
	// the length allows it at all.
	function automatic logic [ADDR_W-1:0] pick_phys(input logic [LEN_W-1:0] len);
		longint unsigned room;
		room = (len > 33'h1_0000_0000) ? 64'h0 : 64'h1_0000_0000 - len;
		return ADDR_W'({$urandom, $urandom} % (room + 1));
	endfunction

	// Builds one random region. Most are well formed lane growth that should merge,
	// some reuse a lane edge with other access levels, some land inside a lane,
	// some are invalid on purpose, and the rest are noise over the whole space.
	task automatic make_region(output logic [ADDR_W-1:0] v, output logic [ADDR_W-1:0] p,
			output logic [LEN_W-1:0] len, output logic [ACC_W-1:0] u,
			output logic [ACC_W-1:0] s);
		int          kind;
		int          lane;
		logic [31:0] base;
		logic [63:0] raw;
		kind = $urandom_range(0, 99);
		lane = $urandom_range(0, NUM_LANES - 1);
		base = LANE_SPAN * lane;
		len = LEN_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 32'h10_0000 : 32'h1000));
		u = lane_user[lane];
		s = lane_system[lane];
		if (kind >= 63 && kind < 78 && lane_hi[lane] != lane_lo[lane]) begin
			// Lands inside what the lane has been offered so far.
			v = lane_lo[lane] + ($urandom % (lane_hi[lane] - lane_lo[lane]));
			p = pick_phys(len);
		end else if (kind >= 55 && kind < 63) begin
			// Meets the lane's upper edge with a different user level.
			u = u ^ ACC_W'($urandom_range(1, 3));
			s = ACC_W'($urandom_range(0, 3));
			v = lane_hi[lane];
			lane_hi[lane] = ADDR_W'(lane_hi[lane] + len);
			p = pick_phys(len);
		end else if (kind >= 78 && kind < 90) begin
			u = ACC_W'($urandom_range(0, 3));
			s = ACC_W'($urandom_range(0, 3));
			v = $urandom;
			p = $urandom;
			case (bad_kind_t'($urandom_range(0, 3)))
				BAD_ZERO: begin
					len = '0;
				end
				BAD_VIRT_END: begin
					len = 33'h1_0000_0000 - {1'b0, v} + LEN_W'($urandom_range(1, 4096));
				end
				BAD_PHYS_END: begin
					p = $urandom_range(32'hFFFF_F000, 32'hFFFF_FFFF);
					len = 33'h1_0000_0000 - {1'b0, p} + LEN_W'($urandom_range(1, 4096));
				end
				default: begin
					len = {1'b1, 32'($urandom)};
				end
			endcase
		end else if (kind >= 90) begin
			raw = {$urandom, $urandom} >> $urandom_range(0, 63);
			len = raw[LEN_W-1:0];
			v = $urandom;
			p = ($urandom_range(0, 1) == 1) ? pick_phys(len) : ADDR_W'($urandom);
			u = ACC_W'($urandom_range(0, 3));
			s = ACC_W'($urandom_range(0, 3));
		end else begin
			// Grows the lane down at random when there is room below, otherwise up.
			if ($urandom_range(0, 1) == 1 && lane_lo[lane] > base + len) begin
				lane_lo[lane] = ADDR_W'(lane_lo[lane] - len);
				v = lane_lo[lane];
			end else begin
				v = lane_hi[lane];
				lane_hi[lane] = ADDR_W'(lane_hi[lane] + len);
			end
			p = pick_phys(len);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] v;
		logic [ADDR_W-1:0] p;
		logic [LEN_W-1:0]  len;
		logic [ACC_W-1:0]  u;
		logic [ACC_W-1:0]  s;

		for (int i = 0; i < NUM_LANES; i++) begin
			lane_lo[i] = LANE_SPAN * i + LANE_SPAN / 2;
			lane_hi[i] = lane_lo[i];
			lane_user[i] = ACC_W'($urandom_range(0, 3));
			lane_system[i] = ACC_W'($urandom_range(0, 3));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Invalid regions on an empty table: zero length, virtual end past the top,
		// physical end past the top, and the largest length the field can hold.
		send_region(32'hD000_0000, 32'h0, 33'h0, 2'd0, 2'd0);
		send_region(32'hFFFF_FFFF, 32'h0, 33'h2, 2'd0, 2'd0);
		send_region(32'hD000_0000, 32'hFFFF_FFF0, 33'h20, 2'd1, 2'd1);
		send_region(32'h0, 32'h0, 33'h1_FFFF_FFFF, 2'd2, 2'd2);
		// Append, then merge above and below the same slot; the lower merge moves
		// the slot's base down.
		send_region(32'hD000_0000, 32'h0, 33'h1000, 2'd0, 2'd0);
		send_region(32'hD000_1000, 32'h100, 33'h1000, 2'd0, 2'd0);
		send_region(32'hCFFF_F000, 32'h200, 33'h1000, 2'd0, 2'd0);
		// Touches the slot but with another user level, so it is appended.
		send_region(32'hD000_2000, 32'h300, 33'h1000, 2'd1, 2'd0);
		// Overlap inside the first slot, and the whole address space at once.
		send_region(32'hD000_0800, 32'h400, 33'h10, 2'd0, 2'd0);
		send_region(32'h0, 32'h0, 33'h1_0000_0000, 2'd0, 2'd0);
		send_region(32'h10, 32'h0, 33'h0_FFFF_FFF0, 2'd2, 2'd1);
		// Access code 3 at the very top byte, then merged with the byte below it.
		send_region(32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1, 2'd3, 2'd3);
		send_region(32'hFFFF_FFFE, 32'h0, 33'h1, 2'd3, 2'd3);
		// A region that touches an earlier slot with equal access merges there even
		// though it also overlaps a later slot.
		send_region(32'hE000_1000, 32'h1000, 33'h1000, 2'd2, 2'd1);
		send_region(32'hE000_3000, 32'h2000, 33'h1000, 2'd2, 2'd2);
		send_region(32'hE000_2000, 32'h3000, 33'h1800, 2'd2, 2'd1);
		// Touches an earlier slot with other access levels and overlaps a later one: overlap.
		send_region(32'hE000_3800, 32'h4000, 33'h1000, 2'd2, 2'd2);

		repeat (RANDOM_WORDS) begin
			make_region(v, p, len, u, s);
			send_region(v, p, len, u, s);
		end
		region_valid <= 1'b0;

		// One edge first so the checker's count includes the last word taken.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
